[hdl/prc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package prc_pkg;

  // Field and arithmetic sizes.
  localparam int unsigned DataWidth   = 16;
  localparam int unsigned Iterations  = 16;
  localparam int unsigned Guard       = 24;
  localparam int unsigned AngleShift  = 32 - DataWidth;
  // Lengths carry the guard bits, two bits of CORDIC and root-two growth and a sign.
  localparam int unsigned CordicWidth = DataWidth + Guard + 4;
  // Internal angles are 32-bit binary angles with headroom for the flip and the sum.
  localparam int unsigned ZWidth      = 34;
  localparam int unsigned HiWidth     = CordicWidth - 32;
  localparam int unsigned HiProdWidth = HiWidth + 32;
  localparam int unsigned ProdWidth   = HiProdWidth + 1;
  localparam int unsigned MagWidth    = ProdWidth + 1 - Guard;
  localparam int unsigned AngRndWidth = ZWidth + 1 - AngleShift;

  // Accept edge to the edge at which the result word is taken.
  localparam int unsigned Latency     = Iterations + 5;

  // Inverse CORDIC gain as a 0.32 fraction.
  localparam logic [31:0] KInv = 32'd2608131496;

  localparam logic ModeRectToPolar = 1'b0;
  localparam logic ModePolarToRect = 1'b1;

  typedef logic signed [CordicWidth-1:0] cvec_t;
  typedef logic signed [ZWidth-1:0]      zang_t;

  localparam zang_t ZQuarter = zang_t'(1) <<< 30;
  localparam zang_t ZHalf    = zang_t'(1) <<< 31;

  // atan(2^-i) in units where 2^31 is pi.
  localparam logic [31:0] AtanTab [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

  // Cases of rectangular to polar that bypass the iterations.
  typedef enum logic [1:0] {
    SpecNone,
    SpecOrigin,
    SpecYPos,
    SpecYNeg
  } spec_e;

  typedef struct packed {
    logic                 mode;
    logic                 flip;
    spec_e                spec;
    logic [DataWidth-1:0] abs_y;
  } side_t;

endpackage

`default_nettype wire

[hdl/polar_rect_convert.sv]
`timescale 1ns / 1ps
`default_nettype none

// Rectangular to polar and polar to rectangular conversion by a fully unrolled
// CORDIC pipeline. A word is taken at every rising edge at which start_i is high;
// busy_o never rises, so a word may be offered in every cycle, and the result
// of each word is strobed on valid_o for one cycle, in the order the words came
// in. The pipeline has one register stage for the set-up, one for each of the
// sixteen CORDIC micro-rotations, and four for gain compensation (magnitude,
// split partial products, their sum, rounding and output selection). The
// receiver must take every result in the cycle it is shown. Angles are binary
// angles in which 32768 stands for pi; with req_type_i low the block returns
// the length and the half-plane arctangent (a point with negative x gets the
// angle of its mirror image through the origin) and flags the origin as having
// no defined angle; with req_type_i high it returns the rectangular components.
// The fields of the unused mode read as zero.

module polar_rect_convert (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  output logic                                   busy_o,
  input  logic                                   req_type_i,
  input  logic signed [prc_pkg::DataWidth-1:0]   coord_x_i,
  input  logic signed [prc_pkg::DataWidth-1:0]   coord_y_i,
  input  logic        [prc_pkg::DataWidth-1:0]   radius_in_i,
  input  logic signed [prc_pkg::DataWidth-1:0]   angle_in_i,
  output logic                                   valid_o,
  output logic        [prc_pkg::DataWidth-1:0]   radius_out_o,
  output logic signed [prc_pkg::DataWidth-1:0]   angle_out_o,
  output logic                                   undefined_angle_o,
  output logic signed [prc_pkg::DataWidth:0]     rect_x_o,
  output logic signed [prc_pkg::DataWidth:0]     rect_y_o
);

  import prc_pkg::*;

  localparam logic signed [DataWidth-1:0] QuarterAngle = DataWidth'(1) <<< (DataWidth - 2);
  localparam logic [MagWidth-1:0]      LenMax    = MagWidth'({DataWidth{1'b1}});
  localparam logic [ProdWidth:0]       LenHalf   = (ProdWidth + 1)'(1) << (Guard - 1);
  localparam logic [ZWidth:0]          AngHalf   = (ZWidth + 1)'(1) << (AngleShift - 1);
  localparam logic [AngRndWidth-1:0]   AngLimit  = AngRndWidth'(QuarterAngle);

  // The pipeline never holds off a word, so a start is always taken.
  logic accept;
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // ---------------------------------------------------------------------------
  // Set-up stage: select the mode, fold the input into the right half-plane or
  // the central half turn, and spot the cases that skip the iterations.
  // ---------------------------------------------------------------------------
  logic signed [DataWidth:0] x_ext, y_ext, x_fold, y_fold;
  zang_t                     z_raw;
  cvec_t                     cx0_d, cy0_d;
  zang_t                     z0_d;
  side_t                     side0_d;

  always_comb begin
    x_ext  = {coord_x_i[DataWidth-1], coord_x_i};
    y_ext  = {coord_y_i[DataWidth-1], coord_y_i};
    // A negative x is mirrored through the origin, which keeps the ratio of y to x.
    x_fold = coord_x_i[DataWidth-1] ? -x_ext : x_ext;
    y_fold = coord_x_i[DataWidth-1] ? -y_ext : y_ext;
    z_raw  = zang_t'(angle_in_i) <<< AngleShift;

    side0_d.mode  = req_type_i;
    side0_d.flip  = 1'b0;
    side0_d.abs_y = coord_y_i[DataWidth-1] ? (~coord_y_i + 1'b1) : coord_y_i;
    side0_d.spec  = SpecNone;

    if (req_type_i == ModeRectToPolar) begin
      cx0_d = cvec_t'(x_fold) <<< Guard;
      cy0_d = cvec_t'(y_fold) <<< Guard;
      z0_d  = '0;
      if (coord_x_i == '0) begin
        if (coord_y_i == '0) begin
          side0_d.spec = SpecOrigin;
        end else if (coord_y_i[DataWidth-1]) begin
          side0_d.spec = SpecYNeg;
        end else begin
          side0_d.spec = SpecYPos;
        end
      end
    end else begin
      cx0_d = cvec_t'({1'b0, radius_in_i}) <<< Guard;
      cy0_d = '0;
      // Beyond a quarter turn the angle is moved by pi and the result negated.
      if (z_raw > ZQuarter) begin
        z0_d         = z_raw - ZHalf;
        side0_d.flip = 1'b1;
      end else if (z_raw < -ZQuarter) begin
        z0_d         = z_raw + ZHalf;
        side0_d.flip = 1'b1;
      end else begin
        z0_d = z_raw;
      end
    end
  end

  // Stage k of these arrays holds the word before micro-rotation k.
  cvec_t cx_q   [Iterations+1];
  cvec_t cy_q   [Iterations+1];
  zang_t z_q    [Iterations+1];
  side_t side_q [Iterations+1];
  logic  vld_q  [Iterations+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    cx_q[0]   <= cx0_d;
    cy_q[0]   <= cy0_d;
    z_q[0]    <= z0_d;
    side_q[0] <= side0_d;
  end

  // ---------------------------------------------------------------------------
  // Micro-rotations, one register stage each. Vectoring (rectangular to polar)
  // steers by the sign of y, rotation (polar to rectangular) by the sign of the
  // residual angle. The shifts are arithmetic, so they round towards minus
  // infinity.
  // ---------------------------------------------------------------------------
  for (genvar k = 0; k < Iterations; k++) begin : g_iter
    cvec_t dx, dy, cx_d, cy_d;
    zang_t step, z_d;
    logic  turn_cw;

    always_comb begin
      dx      = cy_q[k] >>> k;
      dy      = cx_q[k] >>> k;
      step    = zang_t'(AtanTab[k]);
      turn_cw = side_q[k].mode ? z_q[k][ZWidth-1] : !cy_q[k][CordicWidth-1];
      if (turn_cw) begin
        cx_d = cx_q[k] + dx;
        cy_d = cy_q[k] - dy;
        z_d  = z_q[k] + step;
      end else begin
        cx_d = cx_q[k] - dx;
        cy_d = cy_q[k] + dy;
        z_d  = z_q[k] - step;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      cx_q[k+1]   <= cx_d;
      cy_q[k+1]   <= cy_d;
      z_q[k+1]    <= z_d;
      side_q[k+1] <= side_q[k];
    end
  end

  // ---------------------------------------------------------------------------
  // Gain compensation, first stage: split lengths and angle into sign and
  // magnitude, since the scaling and the rounding are symmetric about zero.
  // ---------------------------------------------------------------------------
  logic [CordicWidth-1:0] mx_d, my_d, mx_q, my_q;
  logic [ZWidth-1:0]      az_d, az_q;
  logic                   sx_m1_q, sy_m1_q, sz_m1_q;
  side_t                  side_m1_q;
  logic                   vld_m1_q;

  always_comb begin
    mx_d = cx_q[Iterations][CordicWidth-1] ? -cx_q[Iterations] : cx_q[Iterations];
    my_d = cy_q[Iterations][CordicWidth-1] ? -cy_q[Iterations] : cy_q[Iterations];
    az_d = z_q[Iterations][ZWidth-1] ? -z_q[Iterations] : z_q[Iterations];
  end

  always_ff @(posedge clk_i) begin
    mx_q      <= mx_d;
    my_q      <= my_d;
    az_q      <= az_d;
    sx_m1_q   <= cx_q[Iterations][CordicWidth-1];
    sy_m1_q   <= cy_q[Iterations][CordicWidth-1];
    sz_m1_q   <= z_q[Iterations][ZWidth-1];
    side_m1_q <= side_q[Iterations];
  end

  // Second stage: partial products of the magnitudes with the inverse gain,
  // low 32 bits and high part apart; the angle is rounded and limited here.
  logic [63:0]              px_lo_q, py_lo_q;
  logic [HiProdWidth-1:0]   px_hi_q, py_hi_q;
  logic [ZWidth:0]          az_rnd;
  logic [AngRndWidth-1:0]   az_mag;
  logic [DataWidth-1:0]     ang_mag;
  logic signed [DataWidth-1:0] ang_d, ang_m2_q, ang_m3_q;
  logic                     sx_m2_q, sy_m2_q;
  side_t                    side_m2_q;
  logic                     vld_m2_q;

  always_comb begin
    az_rnd  = (ZWidth + 1)'(az_q) + AngHalf;
    az_mag  = az_rnd[ZWidth:AngleShift];
    ang_mag = (az_mag > AngLimit) ? QuarterAngle : az_mag[DataWidth-1:0];
    ang_d   = sz_m1_q ? -ang_mag : ang_mag;
  end

  always_ff @(posedge clk_i) begin
    px_lo_q   <= 64'(mx_q[31:0]) * 64'(KInv);
    py_lo_q   <= 64'(my_q[31:0]) * 64'(KInv);
    px_hi_q   <= HiProdWidth'(mx_q[CordicWidth-1:32]) * HiProdWidth'(KInv);
    py_hi_q   <= HiProdWidth'(my_q[CordicWidth-1:32]) * HiProdWidth'(KInv);
    ang_m2_q  <= ang_d;
    sx_m2_q   <= sx_m1_q;
    sy_m2_q   <= sy_m1_q;
    side_m2_q <= side_m1_q;
  end

  // Third stage: the scaled magnitude is the high product plus the integer part
  // of the low one, i.e. the product truncated to whole units.
  logic [ProdWidth-1:0] px_q, py_q;
  logic                 sx_m3_q, sy_m3_q;
  side_t                side_m3_q;
  logic                 vld_m3_q;

  always_ff @(posedge clk_i) begin
    px_q      <= ProdWidth'(px_hi_q) + ProdWidth'(px_lo_q[63:32]);
    py_q      <= ProdWidth'(py_hi_q) + ProdWidth'(py_lo_q[63:32]);
    ang_m3_q  <= ang_m2_q;
    sx_m3_q   <= sx_m2_q;
    sy_m3_q   <= sy_m2_q;
    side_m3_q <= side_m2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_m1_q <= 1'b0;
      vld_m2_q <= 1'b0;
      vld_m3_q <= 1'b0;
    end else begin
      vld_m1_q <= vld_q[Iterations];
      vld_m2_q <= vld_m1_q;
      vld_m3_q <= vld_m2_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Output stage: drop the guard bits with rounding half away from zero,
  // saturate, restore signs and pick the fields of the mode in use.
  // ---------------------------------------------------------------------------
  logic [ProdWidth:0]       rx_rnd, ry_rnd;
  logic [MagWidth-1:0]      rx_mag, ry_mag;
  logic [DataWidth-1:0]     rx_sat, ry_sat;
  logic [DataWidth:0]       rx_ext, ry_ext;
  logic                     rx_neg, ry_neg;
  logic [DataWidth-1:0]     radius_out_d, radius_out_q;
  logic signed [DataWidth-1:0] angle_out_d, angle_out_q;
  logic                     undefined_angle_d, undefined_angle_q;
  logic signed [DataWidth:0]   rect_x_d, rect_x_q, rect_y_d, rect_y_q;
  logic                     valid_q;

  always_comb begin
    rx_rnd = (ProdWidth + 1)'(px_q) + LenHalf;
    ry_rnd = (ProdWidth + 1)'(py_q) + LenHalf;
    rx_mag = rx_rnd[ProdWidth:Guard];
    ry_mag = ry_rnd[ProdWidth:Guard];
    rx_sat = (rx_mag > LenMax) ? {DataWidth{1'b1}} : rx_mag[DataWidth-1:0];
    ry_sat = (ry_mag > LenMax) ? {DataWidth{1'b1}} : ry_mag[DataWidth-1:0];
    rx_ext = {1'b0, rx_sat};
    ry_ext = {1'b0, ry_sat};
    rx_neg = sx_m3_q ^ side_m3_q.flip;
    ry_neg = sy_m3_q ^ side_m3_q.flip;

    radius_out_d      = '0;
    angle_out_d       = '0;
    undefined_angle_d = 1'b0;
    rect_x_d          = '0;
    rect_y_d          = '0;

    if (side_m3_q.mode == ModePolarToRect) begin
      rect_x_d = rx_neg ? (~rx_ext + 1'b1) : rx_ext;
      rect_y_d = ry_neg ? (~ry_ext + 1'b1) : ry_ext;
    end else begin
      unique case (side_m3_q.spec)
        SpecNone: begin
          // A negative length cannot be shown and reads as zero.
          radius_out_d = sx_m3_q ? '0 : rx_sat;
          angle_out_d  = ang_m3_q;
        end
        SpecOrigin: begin
          undefined_angle_d = 1'b1;
        end
        SpecYPos: begin
          radius_out_d = side_m3_q.abs_y;
          angle_out_d  = QuarterAngle;
        end
        SpecYNeg: begin
          radius_out_d = side_m3_q.abs_y;
          angle_out_d  = -QuarterAngle;
        end
        default: begin
          radius_out_d = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= vld_m3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    radius_out_q      <= radius_out_d;
    angle_out_q       <= angle_out_d;
    undefined_angle_q <= undefined_angle_d;
    rect_x_q          <= rect_x_d;
    rect_y_q          <= rect_y_d;
  end

  assign valid_o           = valid_q;
  assign radius_out_o      = radius_out_q;
  assign angle_out_o       = angle_out_q;
  assign undefined_angle_o = undefined_angle_q;
  assign rect_x_o          = rect_x_q;
  assign rect_y_o          = rect_y_q;

endmodule

`default_nettype wire

[hdl/prc_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module prc_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 start_i,
  input logic                                 busy_o,
  input logic                                 req_type_i,
  input logic signed [prc_pkg::DataWidth-1:0] coord_x_i,
  input logic signed [prc_pkg::DataWidth-1:0] coord_y_i,
  input logic                                 valid_o,
  input logic        [prc_pkg::DataWidth-1:0] radius_out_o,
  input logic signed [prc_pkg::DataWidth-1:0] angle_out_o,
  input logic                                 undefined_angle_o,
  input logic signed [prc_pkg::DataWidth:0]   rect_x_o,
  input logic signed [prc_pkg::DataWidth:0]   rect_y_o
);

  import prc_pkg::*;

  // Every accepted word yields its result after the fixed latency.
  a_result_follows: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##Latency valid_o
  ) else $error("accepted word produced no result at the expected latency");

  // No result appears without a word accepted the latency before.
  a_no_stray_result: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start_i && !busy_o, Latency)
  ) else $error("result strobed without a matching accepted word");

  // The origin in rectangular to polar mode gives the undefined-angle word.
  a_origin_flag: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && req_type_i == ModeRectToPolar &&
     coord_x_i == '0 && coord_y_i == '0)
    |-> ##Latency (undefined_angle_o && radius_out_o == '0 && angle_out_o == '0)
  ) else $error("origin did not give a zero, undefined-angle result");

  // Rectangular results and polar results never share a word.
  a_mode_fields: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (rect_x_o != '0 || rect_y_o != '0))
    |-> (radius_out_o == '0 && angle_out_o == '0 && !undefined_angle_o)
  ) else $error("fields of both modes set in one result");

endmodule

bind polar_rect_convert prc_checker u_prc_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .start_i           (start_i),
  .busy_o            (busy_o),
  .req_type_i        (req_type_i),
  .coord_x_i         (coord_x_i),
  .coord_y_i         (coord_y_i),
  .valid_o           (valid_o),
  .radius_out_o      (radius_out_o),
  .angle_out_o       (angle_out_o),
  .undefined_angle_o (undefined_angle_o),
  .rect_x_o          (rect_x_o),
  .rect_y_o          (rect_y_o)
);

`default_nettype wire
